>>> rtl/pcsd_pkg.sv
// ----------------------------------------------------------------------------
// pcsd_pkg
// shared constants, register codes and types of the pedal calibrate, smooth
// and dead band block
// ----------------------------------------------------------------------------
package pcsd_pkg;

    localparam int FULL_SCALE  = 1023;
    localparam int ALPHA_BITS  = 16;
    localparam int LOAD_BITS   = 24;
    localparam int NUM_CH      = 3;
    localparam int CH_W        = $clog2(NUM_CH);
    localparam int SAMPLE_W    = 10;
    localparam int DEAD_W      = 10;
    localparam int LEVEL_W     = $clog2(FULL_SCALE + 1);
    localparam int NUM_W       = LOAD_BITS + 1;
    localparam int SPAN_W      = LOAD_BITS + 2;
    localparam int DIVD_W      = NUM_W + LEVEL_W;
    localparam int PROD_W      = ALPHA_BITS + LEVEL_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;

    localparam logic [CH_W-1:0] CH_CLUTCH   = CH_W'(0);
    localparam logic [CH_W-1:0] CH_THROTTLE = CH_W'(1);
    localparam logic [CH_W-1:0] CH_BRAKE    = CH_W'(2);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CLUTCH_LOW,
        REG_CLUTCH_HIGH,
        REG_THROTTLE_LOW,
        REG_THROTTLE_HIGH,
        REG_BRAKE_LOW,
        REG_BRAKE_HIGH,
        REG_DEAD_BAND,
        REG_SMOOTHING
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0]                clutch_low;
        logic [SAMPLE_W-1:0]                clutch_high;
        logic [SAMPLE_W-1:0]                throttle_low;
        logic [SAMPLE_W-1:0]                throttle_high;
        logic signed [LOAD_BITS-1:0]        brake_low;
        logic signed [LOAD_BITS-1:0]        brake_high;
        logic [DEAD_W-1:0]                  dead_band;
        logic [NUM_CH-1:0][ALPHA_BITS-1:0]  alpha;
    } t_cfg;

    localparam logic [SAMPLE_W-1:0]   CLUTCH_LOW_RST    = SAMPLE_W'(0);
    localparam logic [SAMPLE_W-1:0]   CLUTCH_HIGH_RST   = SAMPLE_W'(800);
    localparam logic [SAMPLE_W-1:0]   THROTTLE_LOW_RST  = SAMPLE_W'(0);
    localparam logic [SAMPLE_W-1:0]   THROTTLE_HIGH_RST = SAMPLE_W'(800);
    localparam logic [LOAD_BITS-1:0]  BRAKE_LOW_RST     = LOAD_BITS'(0);
    localparam logic [LOAD_BITS-1:0]  BRAKE_HIGH_RST    = LOAD_BITS'(200000);
    localparam logic [DEAD_W-1:0]     DEAD_BAND_RST     = DEAD_W'(20);
    localparam logic [NUM_CH-1:0][ALPHA_BITS-1:0] ALPHA_RST =
        {ALPHA_BITS'(16'h0CCD), ALPHA_BITS'(16'h2666), ALPHA_BITS'(16'h199A)};

    // how a channel gets its mapped value
    typedef enum logic [1:0] {
        K_ZERO,
        K_FULL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   den;
    } t_chan_job;

    typedef struct packed {
        t_chan_job [NUM_CH-1:0] ch;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAP,
        BK_DIV,
        BK_MUL,
        BK_ADD
    } t_back_state;

endpackage

>>> rtl/pcsd_queue.sv
// ----------------------------------------------------------------------------
// pcsd_queue
// small register queue between the classify front and the processing back
// ----------------------------------------------------------------------------
module pcsd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcsd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

>>> rtl/pcsd_front.sv
// ----------------------------------------------------------------------------
// pcsd_front
// takes items, clamps each reading to its window and classifies the mapping
// ----------------------------------------------------------------------------
module pcsd_front (
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [pcsd_pkg::SAMPLE_W-1:0]         i_clutch_sample,
    input  logic [pcsd_pkg::SAMPLE_W-1:0]         i_throttle_sample,
    input  logic signed [pcsd_pkg::LOAD_BITS-1:0] i_brake_sample,
    input  pcsd_pkg::t_cfg                        i_cfg,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output pcsd_pkg::t_job                        o_job
);

    localparam int NUM_W  = pcsd_pkg::NUM_W;
    localparam int SPAN_W = pcsd_pkg::SPAN_W;

    function automatic pcsd_pkg::t_chan_job classify(
        input logic signed [NUM_W-1:0] x,
        input logic signed [NUM_W-1:0] lo,
        input logic signed [NUM_W-1:0] hi
    );
        logic signed [SPAN_W-1:0] span;
        logic signed [SPAN_W-1:0] off;
        logic signed [NUM_W-1:0]  c;
        pcsd_pkg::t_chan_job      j;
        span = SPAN_W'(hi) - SPAN_W'(lo);
        c    = (x < lo) ? lo : ((x > hi) ? hi : x);
        off  = SPAN_W'(c) - SPAN_W'(lo);
        j.num = off[NUM_W-1:0];
        j.den = span[NUM_W-1:0];
        if (span == '0) begin
            j.kind = pcsd_pkg::K_ZERO;
        end else if (span < 0) begin
            // reversed window: below low maps to zero, anything else to full
            j.kind = (x < lo) ? pcsd_pkg::K_ZERO : pcsd_pkg::K_FULL;
        end else begin
            j.kind = pcsd_pkg::K_DIV;
        end
        return j;
    endfunction

    logic signed [NUM_W-1:0] c_x, c_lo, c_hi;
    logic signed [NUM_W-1:0] t_x, t_lo, t_hi;
    logic signed [NUM_W-1:0] b_x, b_lo, b_hi;

    assign c_x  = signed'(NUM_W'(i_clutch_sample));
    assign c_lo = signed'(NUM_W'(i_cfg.clutch_low));
    assign c_hi = signed'(NUM_W'(i_cfg.clutch_high));
    assign t_x  = signed'(NUM_W'(i_throttle_sample));
    assign t_lo = signed'(NUM_W'(i_cfg.throttle_low));
    assign t_hi = signed'(NUM_W'(i_cfg.throttle_high));
    assign b_x  = NUM_W'(i_brake_sample);
    assign b_lo = NUM_W'(i_cfg.brake_low);
    assign b_hi = NUM_W'(i_cfg.brake_high);

    always_comb begin
        o_job.ch[pcsd_pkg::CH_CLUTCH]   = classify(c_x, c_lo, c_hi);
        o_job.ch[pcsd_pkg::CH_THROTTLE] = classify(t_x, t_lo, t_hi);
        o_job.ch[pcsd_pkg::CH_BRAKE]    = classify(b_x, b_lo, b_hi);
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

>>> rtl/pcsd_div.sv
// ----------------------------------------------------------------------------
// pcsd_div
// restoring divider, one quotient bit per cycle: num * FULL_SCALE / den
// ----------------------------------------------------------------------------
module pcsd_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pcsd_pkg::NUM_W-1:0]        i_num,
    input  logic [pcsd_pkg::NUM_W-1:0]        i_den,
    output logic                              o_done,
    output logic [pcsd_pkg::LEVEL_W-1:0]      o_quot
);

    localparam int DIVD_W  = pcsd_pkg::DIVD_W;
    localparam int LEVEL_W = pcsd_pkg::LEVEL_W;
    localparam int CNT_W   = $clog2(LEVEL_W + 1);

    logic [DIVD_W-1:0]  r_rem,  n_rem;
    logic [DIVD_W-1:0]  r_dsh,  n_dsh;
    logic [LEVEL_W-1:0] r_quot, n_quot;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic               fits;

    assign fits = (r_rem >= r_dsh);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = DIVD_W'(i_num) * DIVD_W'(pcsd_pkg::FULL_SCALE);
            n_dsh  = DIVD_W'(i_den) << (LEVEL_W - 1);
            n_quot = '0;
            n_cnt  = CNT_W'(LEVEL_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = r_rem - r_dsh;
            end
            n_quot = {r_quot[LEVEL_W-2:0], fits};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/pcsd_back.sv
// ----------------------------------------------------------------------------
// pcsd_back
// per channel mapping, moving average and dead band, with the result register
// ----------------------------------------------------------------------------
module pcsd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcsd_pkg::t_cfg                    i_cfg,
    input  logic                              i_q_empty,
    input  pcsd_pkg::t_job                    i_q_data,
    output logic                              o_pop,
    output logic                              o_div_start,
    output logic [pcsd_pkg::NUM_W-1:0]        o_div_num,
    output logic [pcsd_pkg::NUM_W-1:0]        o_div_den,
    input  logic                              i_div_done,
    input  logic [pcsd_pkg::LEVEL_W-1:0]      i_div_quot,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pcsd_pkg::LEVEL_W-1:0]      o_clutch_level,
    output logic [pcsd_pkg::LEVEL_W-1:0]      o_throttle_level,
    output logic [pcsd_pkg::LEVEL_W-1:0]      o_brake_level
);

    localparam int LEVEL_W    = pcsd_pkg::LEVEL_W;
    localparam int ALPHA_BITS = pcsd_pkg::ALPHA_BITS;
    localparam int PROD_W     = pcsd_pkg::PROD_W;
    localparam int NUM_CH     = pcsd_pkg::NUM_CH;
    localparam int CH_W       = pcsd_pkg::CH_W;
    localparam int CMP_W      = (LEVEL_W > pcsd_pkg::DEAD_W) ? LEVEL_W : pcsd_pkg::DEAD_W;

    pcsd_pkg::t_back_state r_state, n_state;

    pcsd_pkg::t_job             r_job;
    logic [CH_W-1:0]            r_ch;
    logic [LEVEL_W-1:0]         r_x;
    logic [LEVEL_W-1:0]         r_fbase;
    logic signed [PROD_W-1:0]   r_prod;
    logic [LEVEL_W-1:0]         r_smooth [NUM_CH];
    logic [LEVEL_W-1:0]         r_level  [NUM_CH];
    logic                       r_out_valid;

    pcsd_pkg::t_chan_job        cur;
    logic                       last;
    logic                       out_free;
    logic                       commit;
    logic [LEVEL_W-1:0]         f_eff;
    logic signed [LEVEL_W:0]    diff;
    logic signed [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]          sum;
    logic [LEVEL_W-1:0]         f_new;
    logic [LEVEL_W-1:0]         f_db;

    assign cur      = r_job.ch[r_ch];
    assign last     = (r_ch == CH_W'(NUM_CH - 1));
    assign out_free = !r_out_valid || i_out_ready;

    // empty filter takes the mapped value first
    assign f_eff = (r_smooth[r_ch] == '0) ? r_x : r_smooth[r_ch];
    assign diff  = signed'({1'b0, r_x}) - signed'({1'b0, f_eff});
    assign prod  = signed'({1'b0, i_cfg.alpha[r_ch]}) * diff;
    assign sum   = PROD_W'({r_fbase, {ALPHA_BITS{1'b0}}}) + PROD_W'(r_prod);
    assign f_new = sum[ALPHA_BITS +: LEVEL_W];
    assign f_db  = (CMP_W'(f_new) < CMP_W'(i_cfg.dead_band)) ? '0 : f_new;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcsd_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = pcsd_pkg::BK_MAP;
                end
            end
            pcsd_pkg::BK_MAP: begin
                n_state = (cur.kind == pcsd_pkg::K_DIV) ? pcsd_pkg::BK_DIV
                                                        : pcsd_pkg::BK_MUL;
            end
            pcsd_pkg::BK_DIV: begin
                if (i_div_done) begin
                    n_state = pcsd_pkg::BK_MUL;
                end
            end
            pcsd_pkg::BK_MUL: begin
                n_state = pcsd_pkg::BK_ADD;
            end
            pcsd_pkg::BK_ADD: begin
                if (!last) begin
                    n_state = pcsd_pkg::BK_MAP;
                end else if (out_free) begin
                    n_state = pcsd_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = pcsd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_div_start = 1'b0;
        commit      = 1'b0;
        case (r_state)
            pcsd_pkg::BK_IDLE: begin
                o_pop = !i_q_empty;
            end
            pcsd_pkg::BK_MAP: begin
                o_div_start = (cur.kind == pcsd_pkg::K_DIV);
            end
            pcsd_pkg::BK_ADD: begin
                commit = !last || out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_div_num = cur.num;
    assign o_div_den = cur.den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcsd_pkg::BK_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_smooth[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_ch <= '0;
            end else if (commit) begin
                r_ch <= last ? '0 : r_ch + 1'b1;
            end
            if (commit) begin
                r_smooth[r_ch] <= f_db;
            end
            if (commit && last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
        if (r_state == pcsd_pkg::BK_MAP) begin
            r_x <= (cur.kind == pcsd_pkg::K_FULL) ? LEVEL_W'(pcsd_pkg::FULL_SCALE) : '0;
        end else if (r_state == pcsd_pkg::BK_DIV && i_div_done) begin
            r_x <= i_div_quot;
        end
        if (r_state == pcsd_pkg::BK_MUL) begin
            r_fbase <= f_eff;
            r_prod  <= prod;
        end
        if (commit && last) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_level[i] <= (CH_W'(i) == r_ch) ? f_db : r_smooth[i];
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_clutch_level   = r_level[pcsd_pkg::CH_CLUTCH];
    assign o_throttle_level = r_level[pcsd_pkg::CH_THROTTLE];
    assign o_brake_level    = r_level[pcsd_pkg::CH_BRAKE];

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcsd_pkg::BK_DIV && i_div_done)
            |-> (i_div_quot <= LEVEL_W'(pcsd_pkg::FULL_SCALE)))
        else $error("mapped value above full scale");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == pcsd_pkg::BK_MAP && r_ch == '0))
        else $error("item not started at first channel");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_level[0])
            && $stable(r_level[1]) && $stable(r_level[2])))
        else $error("pending result overwritten");

endmodule

>>> rtl/pedal_calibrate_smooth_deadzone.sv
// ----------------------------------------------------------------------------
// pedal_calibrate_smooth_deadzone
// three pedal axes: window clamp, linear map, moving average and dead band
// ----------------------------------------------------------------------------
// each channel with a normal window runs through the map, divide, multiply and
// add states and uses the shared one-bit-per-cycle divider; a channel with an
// empty or reversed window skips the divide state. the two-item queue keeps
// taking new items while the back end still works on an earlier one, until it
// fills. reset is synchronous active low and loads the calibration defaults
// and clears the filters.
// ----------------------------------------------------------------------------
module pedal_calibrate_smooth_deadzone #(
    parameter int QUEUE_DEPTH = pcsd_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [pcsd_pkg::SAMPLE_W-1:0]          i_clutch_sample,
    input  logic [pcsd_pkg::SAMPLE_W-1:0]          i_throttle_sample,
    input  logic signed [pcsd_pkg::LOAD_BITS-1:0]  i_brake_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [pcsd_pkg::LEVEL_W-1:0]           o_clutch_level,
    output logic [pcsd_pkg::LEVEL_W-1:0]           o_throttle_level,
    output logic [pcsd_pkg::LEVEL_W-1:0]           o_brake_level,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pcsd_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [pcsd_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [pcsd_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int DATA_W    = pcsd_pkg::CFG_DATA_W;
    localparam int SAMPLE_W  = pcsd_pkg::SAMPLE_W;
    localparam int LOAD_BITS = pcsd_pkg::LOAD_BITS;
    localparam int DEAD_W    = pcsd_pkg::DEAD_W;
    localparam int ALPHA_W   = pcsd_pkg::NUM_CH * pcsd_pkg::ALPHA_BITS;
    localparam int IDX_LSB   = 3;

    pcsd_pkg::t_cfg     r_cfg;
    pcsd_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    pcsd_pkg::t_job     push_job;
    pcsd_pkg::t_job     q_data;
    logic               push, q_full, q_empty, pop;
    logic               div_start, div_done;
    logic [pcsd_pkg::NUM_W-1:0]   div_num, div_den;
    logic [pcsd_pkg::LEVEL_W-1:0] div_quot;

    assign reg_idx = pcsd_pkg::t_reg_idx'(paddr[IDX_LSB +: pcsd_pkg::REG_IDX_W]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clutch_low    <= pcsd_pkg::CLUTCH_LOW_RST;
            r_cfg.clutch_high   <= pcsd_pkg::CLUTCH_HIGH_RST;
            r_cfg.throttle_low  <= pcsd_pkg::THROTTLE_LOW_RST;
            r_cfg.throttle_high <= pcsd_pkg::THROTTLE_HIGH_RST;
            r_cfg.brake_low     <= pcsd_pkg::BRAKE_LOW_RST;
            r_cfg.brake_high    <= pcsd_pkg::BRAKE_HIGH_RST;
            r_cfg.dead_band     <= pcsd_pkg::DEAD_BAND_RST;
            r_cfg.alpha         <= pcsd_pkg::ALPHA_RST;
        end else if (wr_en) begin
            case (reg_idx)
                pcsd_pkg::REG_CLUTCH_LOW:    r_cfg.clutch_low    <= pwdata[SAMPLE_W-1:0];
                pcsd_pkg::REG_CLUTCH_HIGH:   r_cfg.clutch_high   <= pwdata[SAMPLE_W-1:0];
                pcsd_pkg::REG_THROTTLE_LOW:  r_cfg.throttle_low  <= pwdata[SAMPLE_W-1:0];
                pcsd_pkg::REG_THROTTLE_HIGH: r_cfg.throttle_high <= pwdata[SAMPLE_W-1:0];
                pcsd_pkg::REG_BRAKE_LOW:     r_cfg.brake_low     <= pwdata[LOAD_BITS-1:0];
                pcsd_pkg::REG_BRAKE_HIGH:    r_cfg.brake_high    <= pwdata[LOAD_BITS-1:0];
                pcsd_pkg::REG_DEAD_BAND:     r_cfg.dead_band     <= pwdata[DEAD_W-1:0];
                pcsd_pkg::REG_SMOOTHING:     r_cfg.alpha         <= pwdata[ALPHA_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pcsd_pkg::REG_CLUTCH_LOW:    prdata = DATA_W'(r_cfg.clutch_low);
            pcsd_pkg::REG_CLUTCH_HIGH:   prdata = DATA_W'(r_cfg.clutch_high);
            pcsd_pkg::REG_THROTTLE_LOW:  prdata = DATA_W'(r_cfg.throttle_low);
            pcsd_pkg::REG_THROTTLE_HIGH: prdata = DATA_W'(r_cfg.throttle_high);
            pcsd_pkg::REG_BRAKE_LOW:
                prdata = {{(DATA_W - LOAD_BITS){1'b0}}, r_cfg.brake_low};
            pcsd_pkg::REG_BRAKE_HIGH:
                prdata = {{(DATA_W - LOAD_BITS){1'b0}}, r_cfg.brake_high};
            pcsd_pkg::REG_DEAD_BAND:     prdata = DATA_W'(r_cfg.dead_band);
            pcsd_pkg::REG_SMOOTHING:     prdata = DATA_W'(r_cfg.alpha);
            default: begin
                prdata = '0;
            end
        endcase
    end

    pcsd_front u_front (
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_clutch_sample   (i_clutch_sample),
        .i_throttle_sample (i_throttle_sample),
        .i_brake_sample    (i_brake_sample),
        .i_cfg             (r_cfg),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_job             (push_job)
    );

    pcsd_queue #(
        .WIDTH ($bits(pcsd_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    pcsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    pcsd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (q_empty),
        .i_q_data         (q_data),
        .o_pop            (pop),
        .o_div_start      (div_start),
        .o_div_num        (div_num),
        .o_div_den        (div_den),
        .i_div_done       (div_done),
        .i_div_quot       (div_quot),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_clutch_level   (o_clutch_level),
        .o_throttle_level (o_throttle_level),
        .o_brake_level    (o_brake_level)
    );

endmodule

>>> sim/pedal_calibrate_smooth_deadzone_tb.sv
// ----------------------------------------------------------------------------
// pedal_calibrate_smooth_deadzone_tb
// self-checking bench for the three-axis pedal calibrate, smooth and dead band
// block: a directed table of corner items and register writes, then random
// calibration phases with random pedal readings. every accepted item is run
// through an in-bench model of the window map and moving average, and each
// result item is compared field by field with the oldest prediction. both
// handshake sides idle at random, the receiver holds off once for a long
// stretch, and the calibration port is only written while the block is empty.
// ----------------------------------------------------------------------------
module pedal_calibrate_smooth_deadzone_tb;

    localparam int LEVEL_W      = pcsd_pkg::LEVEL_W;
    localparam int SAMPLE_W     = pcsd_pkg::SAMPLE_W;
    localparam int LOAD_BITS    = pcsd_pkg::LOAD_BITS;
    localparam int DEAD_W       = pcsd_pkg::DEAD_W;
    localparam int NUM_CH       = pcsd_pkg::NUM_CH;
    localparam int ALPHA_BITS   = pcsd_pkg::ALPHA_BITS;
    localparam int FULL_SCALE   = pcsd_pkg::FULL_SCALE;
    localparam int CFG_DATA_W   = pcsd_pkg::CFG_DATA_W;
    localparam int CFG_ADDR_W   = pcsd_pkg::CFG_ADDR_W;

    localparam int HOLD_CYCLES  = 500;
    localparam int QUIET_LIMIT  = 6000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;

    typedef struct packed {
        logic [LEVEL_W-1:0] clutch;
        logic [LEVEL_W-1:0] throttle;
        logic [LEVEL_W-1:0] brake;
    } t_level_set;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind                    kind;
        pcsd_pkg::t_reg_idx           idx;
        logic [CFG_DATA_W-1:0]        value;
        logic [SAMPLE_W-1:0]          clutch;
        logic [SAMPLE_W-1:0]          throttle;
        logic signed [LOAD_BITS-1:0]  brake;
        bit                           typed;
        t_level_set                   levels;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [SAMPLE_W-1:0]            i_clutch_sample;
    logic [SAMPLE_W-1:0]            i_throttle_sample;
    logic signed [LOAD_BITS-1:0]    i_brake_sample;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [LEVEL_W-1:0]             o_clutch_level;
    logic [LEVEL_W-1:0]             o_throttle_level;
    logic [LEVEL_W-1:0]             o_brake_level;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [CFG_ADDR_W-1:0]          paddr;
    logic [CFG_DATA_W-1:0]          pwdata;
    logic [CFG_DATA_W-1:0]          prdata;
    logic                           pready;

    // calibration copy and filter state of the predictor
    logic [SAMPLE_W-1:0]                cal_clutch_lo   = pcsd_pkg::CLUTCH_LOW_RST;
    logic [SAMPLE_W-1:0]                cal_clutch_hi   = pcsd_pkg::CLUTCH_HIGH_RST;
    logic [SAMPLE_W-1:0]                cal_throttle_lo = pcsd_pkg::THROTTLE_LOW_RST;
    logic [SAMPLE_W-1:0]                cal_throttle_hi = pcsd_pkg::THROTTLE_HIGH_RST;
    logic signed [LOAD_BITS-1:0]        cal_brake_lo    = pcsd_pkg::BRAKE_LOW_RST;
    logic signed [LOAD_BITS-1:0]        cal_brake_hi    = pcsd_pkg::BRAKE_HIGH_RST;
    logic [DEAD_W-1:0]                  cal_dead_band   = pcsd_pkg::DEAD_BAND_RST;
    logic [NUM_CH*ALPHA_BITS-1:0]       cal_alpha       = pcsd_pkg::ALPHA_RST;
    logic [LEVEL_W-1:0]                 flt_clutch      = '0;
    logic [LEVEL_W-1:0]                 flt_throttle    = '0;
    logic [LEVEL_W-1:0]                 flt_brake       = '0;

    t_level_set     levels_due[$];
    t_row           plan[$];
    int             mismatches = 0;
    int             quiet_cycles = 0;
    bit             tx_idle = 1'b1;
    bit             rx_idle = 1'b1;
    bit             hold_req = 1'b0;

    pedal_calibrate_smooth_deadzone u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_clutch_sample   (i_clutch_sample),
        .i_throttle_sample (i_throttle_sample),
        .i_brake_sample    (i_brake_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_clutch_level    (o_clutch_level),
        .o_throttle_level  (o_throttle_level),
        .o_brake_level     (o_brake_level),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [LEVEL_W-1:0] window_map(longint x, longint lo, longint hi);
        longint c;
        longint span;
        c = (x < lo) ? lo : ((x > hi) ? hi : x);
        span = hi - lo;
        if (span == 0) begin
            return '0;
        end
        return LEVEL_W'(((c - lo) * longint'(FULL_SCALE)) / span);
    endfunction

    function automatic logic [LEVEL_W-1:0] ema_next(logic [LEVEL_W-1:0] f,
                                                    logic [LEVEL_W-1:0] x,
                                                    logic [ALPHA_BITS-1:0] a);
        longint unsigned base;
        longint unsigned acc;
        base = (f == 0) ? longint'(x) : longint'(f);
        acc = longint'(a) * x + ((longint'(1) << ALPHA_BITS) - a) * base;
        acc = acc >> ALPHA_BITS;
        if (acc < cal_dead_band) begin
            acc = 0;
        end
        return LEVEL_W'(acc);
    endfunction

    task automatic advance_pedals(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] t,
                                  input logic signed [LOAD_BITS-1:0] b, output t_level_set lv);
        flt_clutch   = ema_next(flt_clutch, window_map(c, cal_clutch_lo, cal_clutch_hi),
                                cal_alpha[ALPHA_BITS-1:0]);
        flt_throttle = ema_next(flt_throttle, window_map(t, cal_throttle_lo, cal_throttle_hi),
                                cal_alpha[2*ALPHA_BITS-1:ALPHA_BITS]);
        flt_brake    = ema_next(flt_brake, window_map(b, cal_brake_lo, cal_brake_hi),
                                cal_alpha[3*ALPHA_BITS-1:2*ALPHA_BITS]);
        lv.clutch   = flt_clutch;
        lv.throttle = flt_throttle;
        lv.brake    = flt_brake;
    endtask

    function automatic void store_cal(pcsd_pkg::t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            pcsd_pkg::REG_CLUTCH_LOW:    cal_clutch_lo   = value[SAMPLE_W-1:0];
            pcsd_pkg::REG_CLUTCH_HIGH:   cal_clutch_hi   = value[SAMPLE_W-1:0];
            pcsd_pkg::REG_THROTTLE_LOW:  cal_throttle_lo = value[SAMPLE_W-1:0];
            pcsd_pkg::REG_THROTTLE_HIGH: cal_throttle_hi = value[SAMPLE_W-1:0];
            pcsd_pkg::REG_BRAKE_LOW:     cal_brake_lo    = value[LOAD_BITS-1:0];
            pcsd_pkg::REG_BRAKE_HIGH:    cal_brake_hi    = value[LOAD_BITS-1:0];
            pcsd_pkg::REG_DEAD_BAND:     cal_dead_band   = value[DEAD_W-1:0];
            pcsd_pkg::REG_SMOOTHING:     cal_alpha       = value[NUM_CH*ALPHA_BITS-1:0];
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // lower valid and wait until every predicted item has come back
    task automatic settle(input int extra);
        i_in_valid = 1'b0;
        while (levels_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic push_item(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] t,
                             input logic signed [LOAD_BITS-1:0] b, input bit typed,
                             input t_level_set typed_lv);
        int gap;
        t_level_set lv;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_clutch_sample   = c;
        i_throttle_sample = t;
        i_brake_sample    = b;
        do @(posedge i_clk); while (!o_in_ready);
        advance_pedals(c, t, b, lv);
        levels_due.push_back(typed ? typed_lv : lv);
        @(negedge i_clk);
    endtask

    task automatic write_cal(input pcsd_pkg::t_reg_idx idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle(2);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'({idx, 3'b000});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        store_cal(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic void plan_item(logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] t,
                                      logic signed [LOAD_BITS-1:0] b, bit typed = 1'b0,
                                      t_level_set lv = '0);
        t_row r;
        r.kind = ROW_ITEM;
        r.idx = pcsd_pkg::REG_CLUTCH_LOW;
        r.value = '0;
        r.clutch = c;
        r.throttle = t;
        r.brake = b;
        r.typed = typed;
        r.levels = lv;
        plan.push_back(r);
    endfunction

    function automatic void plan_write(pcsd_pkg::t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        t_row r;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.value = value;
        r.clutch = '0;
        r.throttle = '0;
        r.brake = '0;
        r.typed = 1'b0;
        r.levels = '0;
        plan.push_back(r);
    endfunction

    task automatic pick_pedal_window(output logic [SAMPLE_W-1:0] lo,
                                     output logic [SAMPLE_W-1:0] hi);
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        a = SAMPLE_W'($urandom);
        b = SAMPLE_W'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = a;
                hi = a;
            end
            2: begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    task automatic pick_load_window(output logic signed [LOAD_BITS-1:0] lo,
                                    output logic signed [LOAD_BITS-1:0] hi);
        logic signed [LOAD_BITS-1:0] a;
        logic signed [LOAD_BITS-1:0] b;
        a = LOAD_BITS'($urandom);
        b = LOAD_BITS'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                lo = {1'b1, {(LOAD_BITS-1){1'b0}}};
                hi = {1'b0, {(LOAD_BITS-1){1'b1}}};
            end
            1: begin
                lo = a;
                hi = a;
            end
            2: begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            3: begin
                lo = a;
                hi = a + LOAD_BITS'($urandom_range(1, 64));
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_pedal(logic [SAMPLE_W-1:0] lo,
                                                       logic [SAMPLE_W-1:0] hi);
        int unsigned mn;
        int unsigned mx;
        mn = (lo < hi) ? lo : hi;
        mx = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'($urandom);
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return SAMPLE_W'($urandom_range(mn, mx));
        endcase
    endfunction

    function automatic logic signed [LOAD_BITS-1:0] draw_load(logic signed [LOAD_BITS-1:0] lo,
                                                              logic signed [LOAD_BITS-1:0] hi);
        longint mn;
        longint mx;
        mn = (lo < hi) ? lo : hi;
        mx = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0: return LOAD_BITS'($urandom);
            1: return $urandom_range(0, 1) ? {1'b0, {(LOAD_BITS-1){1'b1}}}
                                           : {1'b1, {(LOAD_BITS-1){1'b0}}};
            2: return LOAD_BITS'(lo + $signed($urandom_range(0, 2)) - 1);
            default: return LOAD_BITS'(mn + longint'($urandom_range(0, 32'(mx - mn))));
        endcase
    endfunction

    function automatic logic [ALPHA_BITS-1:0] pick_alpha();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return ALPHA_BITS'(1);
            default: return ALPHA_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [DEAD_W-1:0] pick_dead_band();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return DEAD_W'($urandom);
            default: return DEAD_W'($urandom_range(0, 40));
        endcase
    endfunction

    // receiver: random stall per item, one long hold-off on request
    initial begin : receiver
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_level_set want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (levels_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected item %0d/%0d/%0d", o_clutch_level,
                                        o_throttle_level, o_brake_level));
            end else begin
                want = levels_due.pop_front();
                if (o_clutch_level !== want.clutch)
                    flag_mismatch($sformatf("clutch level %0d, expected %0d",
                                            o_clutch_level, want.clutch));
                if (o_throttle_level !== want.throttle)
                    flag_mismatch($sformatf("throttle level %0d, expected %0d",
                                            o_throttle_level, want.throttle));
                if (o_brake_level !== want.brake)
                    flag_mismatch($sformatf("brake level %0d, expected %0d",
                                            o_brake_level, want.brake));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("** pedal_calibrate_smooth_deadzone: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row row;
        logic [SAMPLE_W-1:0] c_lo, c_hi, t_lo, t_hi;
        logic signed [LOAD_BITS-1:0] b_lo, b_hi;
        logic [CFG_DATA_W-1:0] junk;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_clutch_sample   = '0;
        i_throttle_sample = '0;
        i_brake_sample    = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        // directed corners
        plan_item(10'd0, 10'd0, 24'sd0, 1'b1, '{10'd0, 10'd0, 10'd0});
        plan_item(10'd1023, 10'd1023, 24'h7FFFFF, 1'b1, '{10'd1023, 10'd1023, 10'd1023});
        plan_item(10'd0, 10'd0, 24'h800000);
        plan_item(10'd400, 10'd400, 24'sd100000);
        plan_item(10'd799, 10'd801, 24'sd199999);
        plan_write(pcsd_pkg::REG_DEAD_BAND, 64'h0000_F000_0000_FFFF);
        plan_item(10'd0, 10'd0, 24'sd0);
        plan_item(10'd1023, 10'd1023, 24'h7FFFFF);
        plan_write(pcsd_pkg::REG_DEAD_BAND, 64'hFFFF_FFFF_FFFF_FC00);
        plan_write(pcsd_pkg::REG_SMOOTHING, 64'h1234_0000_0000_0000);
        plan_item(10'd512, 10'd512, 24'sd50000);
        plan_write(pcsd_pkg::REG_SMOOTHING, 64'h0000_FFFF_FFFF_FFFF);
        plan_item(10'd1023, 10'd0, 24'h7FFFFF);
        // equal clutch ends, reversed throttle and brake windows
        plan_write(pcsd_pkg::REG_CLUTCH_LOW, 64'h8000_0000_0000_05F4);
        plan_write(pcsd_pkg::REG_CLUTCH_HIGH, 64'h0000_0000_0000_01F4);
        plan_write(pcsd_pkg::REG_THROTTLE_LOW, 64'h0000_0000_0000_0384);
        plan_write(pcsd_pkg::REG_THROTTLE_HIGH, 64'hFFFF_FFFF_FFFF_FC64);
        plan_write(pcsd_pkg::REG_BRAKE_LOW, 64'hFFFF_FFFF_FF7F_FFFF);
        plan_write(pcsd_pkg::REG_BRAKE_HIGH, 64'h0000_0000_0080_0000);
        plan_item(10'd1023, 10'd899, 24'h800000, 1'b1, '{10'd0, 10'd0, 10'd0});
        plan_item(10'd0, 10'd900, 24'h7FFFFF, 1'b1, '{10'd0, 10'd1023, 10'd1023});
        plan_item(10'd500, 10'd1023, 24'sd0, 1'b1, '{10'd0, 10'd1023, 10'd0});
        // full-range windows
        plan_write(pcsd_pkg::REG_BRAKE_LOW, 64'h0000_0000_0080_0000);
        plan_write(pcsd_pkg::REG_BRAKE_HIGH, 64'h5555_0000_007F_FFFF);
        plan_write(pcsd_pkg::REG_THROTTLE_LOW, 64'h0000_0000_0000_0000);
        plan_write(pcsd_pkg::REG_THROTTLE_HIGH, 64'h0000_0000_0000_03FF);
        plan_write(pcsd_pkg::REG_CLUTCH_LOW, 64'h0000_0000_0000_0000);
        plan_write(pcsd_pkg::REG_CLUTCH_HIGH, 64'h0000_0000_0000_03FF);
        plan_item(10'd1023, 10'd1023, 24'h7FFFFF, 1'b1, '{10'd1023, 10'd1023, 10'd1023});
        plan_item(10'd0, 10'd0, 24'h800000);
        plan_item(10'd1, 10'd1, 24'h800001);
        plan_item(10'd341, 10'd682, 24'sd0);
        plan_write(pcsd_pkg::REG_SMOOTHING, 64'h0000_0CCD_2666_199A);
        plan_write(pcsd_pkg::REG_DEAD_BAND, 64'h0000_0000_0000_0014);
        plan_item(10'd100, 10'd200, 24'sd123456);
        plan_item(10'd100, 10'd200, 24'sd123456);
        plan_item(10'd5, 10'd5, -24'sd5);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < plan.size(); k++) begin
            row = plan[k];
            if (row.kind == ROW_WRITE) begin
                write_cal(row.idx, row.value);
            end else begin
                push_item(row.clutch, row.throttle, row.brake, row.typed, row.levels);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            pick_pedal_window(c_lo, c_hi);
            pick_pedal_window(t_lo, t_hi);
            pick_load_window(b_lo, b_hi);
            junk = {$urandom, $urandom};
            write_cal(pcsd_pkg::REG_CLUTCH_LOW, {junk[63:SAMPLE_W], c_lo});
            write_cal(pcsd_pkg::REG_CLUTCH_HIGH, {junk[62:SAMPLE_W-1], c_hi});
            write_cal(pcsd_pkg::REG_THROTTLE_LOW, {junk[61:SAMPLE_W-2], t_lo});
            write_cal(pcsd_pkg::REG_THROTTLE_HIGH, {junk[60:SAMPLE_W-3], t_hi});
            write_cal(pcsd_pkg::REG_BRAKE_LOW, {junk[63:LOAD_BITS], b_lo});
            write_cal(pcsd_pkg::REG_BRAKE_HIGH, {junk[62:LOAD_BITS-1], b_hi});
            write_cal(pcsd_pkg::REG_DEAD_BAND, {junk[59:DEAD_W-4], pick_dead_band()});
            write_cal(pcsd_pkg::REG_SMOOTHING, {junk[63:NUM_CH*ALPHA_BITS],
                                                pick_alpha(), pick_alpha(), pick_alpha()});
            tx_idle = (p % 4 == 0) || (p % 4 == 2);
            rx_idle = (p % 4 == 0) || (p % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 20) begin
                    hold_req = 1'b1;
                end
                if (p == 6 && n == 65) begin
                    settle(0);
                end
                push_item(draw_pedal(c_lo, c_hi), draw_pedal(t_lo, t_hi),
                          draw_load(b_lo, b_hi), 1'b0, '0);
            end
        end

        settle(60);
        if (mismatches == 0) begin
            $display("** pedal_calibrate_smooth_deadzone: PASSED **");
        end else begin
            $display("** pedal_calibrate_smooth_deadzone: FAILED **");
        end
        $finish;
    end

endmodule
